FILE: sv/cwg_pkg.sv
// Shared types, constants and arithmetic helpers for the circle waypoint generator.
`default_nettype none

package cwg_pkg;

  // Q30 constants
  localparam logic [63:0] PI_Q30   = 64'd3373259426;
  localparam logic [63:0] ONE_Q30  = 64'd1073741824;
  localparam logic [63:0] HALF_Q30 = 64'd536870912;

  // Request payload
  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic        [30:0] radius;
  } req_t;

  // Waypoint payload
  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic        [4:0]  point_index;
    logic               last;
    logic               degenerate;
  } pt_t;

  // Normalized request handed from the front end to the emitter
  typedef struct packed {
    logic signed [31:0] cen_x;
    logic signed [31:0] cen_y;
    logic signed [31:0] cen_z;
    logic        [30:0] radius;
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic signed [31:0] uz;
    logic               degenerate;
  } ctx_t;

  // Cosine and sine (Q30) of an in-quadrant angle x, mapped to quadrant q.
  // Evaluated at elaboration only; result is {cos, sin}.
  function automatic logic [63:0] sincos_q30(input logic [63:0] x, input logic [1:0] q);
    logic [63:0]        x2;
    logic [63:0]        ts;
    logic [63:0]        tc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    logic signed [31:0] co;
    logic signed [31:0] so;
    x2 = (x * x + HALF_Q30) >> 30;
    ts = x;
    tc = ONE_Q30;
    s  = $signed(x);
    c  = $signed(ONE_Q30);
    ts = ((ts * x2) >> 30) / 6;   tc = ((tc * x2) >> 30) / 2;   s = s - $signed(ts); c = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 20;  tc = ((tc * x2) >> 30) / 12;  s = s + $signed(ts); c = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 42;  tc = ((tc * x2) >> 30) / 30;  s = s - $signed(ts); c = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 72;  tc = ((tc * x2) >> 30) / 56;  s = s + $signed(ts); c = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 110; tc = ((tc * x2) >> 30) / 90;  s = s - $signed(ts); c = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 156; tc = ((tc * x2) >> 30) / 132; s = s + $signed(ts); c = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 210; tc = ((tc * x2) >> 30) / 182; s = s - $signed(ts); c = c - $signed(tc);
    ts = ((ts * x2) >> 30) / 272; tc = ((tc * x2) >> 30) / 240; s = s + $signed(ts); c = c + $signed(tc);
    ts = ((ts * x2) >> 30) / 342; tc = ((tc * x2) >> 30) / 306; s = s - $signed(ts); c = c - $signed(tc);
    if (s < 0) s = 0;
    if (s > $signed(ONE_Q30)) s = $signed(ONE_Q30);
    if (c < 0) c = 0;
    if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
    case (q)
      2'd0: begin co = 32'(c);  so = 32'(s);  end
      2'd1: begin co = -32'(s); so = 32'(c);  end
      2'd2: begin co = -32'(c); so = -32'(s); end
      default: begin co = 32'(s); so = -32'(c); end
    endcase
    return {co, so};
  endfunction

  // Q60 -> Q30 (or Q46 -> Q16), rounding half away from zero
  function automatic logic signed [33:0] rnd30(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = v + (v < 0 ? $signed(HALF_Q30 - 64'd1) : $signed(HALF_Q30));
    return 34'(t >>> 30);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7fffffff;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

endpackage

`default_nettype wire

FILE: sv/cwg_if.sv
// Valid/ready channel interfaces for requests and waypoints.
`default_nettype none

interface cwg_req_if;
  logic          valid;
  logic          ready;
  cwg_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cwg_pt_if;
  logic         valid;
  logic         ready;
  cwg_pkg::pt_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: sv/cwg_norm.sv
// Front end: difference, scaling, squares, iterative square root and division to a unit vector.
`default_nettype none

module cwg_norm (
  input  wire logic    clk,
  input  wire logic    rst,
  cwg_req_if.sink      req,
  output logic         ctx_valid,
  input  wire logic    ctx_ready,
  output cwg_pkg::ctx_t ctx
);

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic        [30:0] rad;
  } hold_t;

  // stage 1: differences
  logic               s1_v;
  hold_t              s1_h;
  logic signed [32:0] s1_dif [3];
  // stage 2: scaled magnitudes
  logic               s2_v;
  hold_t              s2_h;
  logic [29:0]        s2_sc [3];
  logic [2:0]         s2_neg;
  logic               s2_degen;
  // stage 3: squares
  logic               s3_v;
  hold_t              s3_h;
  logic [59:0]        s3_sq [3];
  logic [29:0]        s3_sc [3];
  logic [2:0]         s3_neg;
  logic               s3_degen;
  // square root unit
  logic               sq_v;
  hold_t              sq_h;
  logic [29:0]        sq_sc [3];
  logic [2:0]         sq_neg;
  logic               sq_degen;
  logic [61:0]        sq_rem;
  logic [62:0]        sq_root;
  logic [62:0]        sq_bit;
  // divider unit
  logic               dv_v;
  hold_t              dv_h;
  logic [2:0]         dv_neg;
  logic               dv_degen;
  logic [30:0]        dv_n;
  logic [30:0]        dv_r [3];
  logic [30:0]        dv_lo [3];
  logic [4:0]         dv_cnt;

  logic req_acc, s2_ld, s3_ld, sq_ld, dv_ld, dv_rel, sq_done;

  // handshake chain
  assign sq_done   = (sq_bit == '0);
  assign dv_rel    = dv_v && (dv_cnt == '0) && ctx_ready;
  assign dv_ld     = sq_v && sq_done && (!dv_v || dv_rel);
  assign sq_ld     = s3_v && (!sq_v || dv_ld);
  assign s3_ld     = s2_v && (!s3_v || sq_ld);
  assign s2_ld     = s1_v && (!s2_v || s3_ld);
  assign req.ready = !s1_v || s2_ld;
  assign req_acc   = req.valid && req.ready;

  // stage 2 logic: magnitudes, bit length of the largest, normalizing shift
  logic [32:0] mag [3];
  logic [32:0] mag_or;
  logic [5:0]  len;
  logic [29:0] sc [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j] = s1_dif[j][32] ? 33'(-s1_dif[j]) : 33'(s1_dif[j]);
    end
    mag_or = mag[0] | mag[1] | mag[2];
    len = '0;
    for (int b = 0; b < 33; b++) begin
      if (mag_or[b]) len = 6'(b + 1);
    end
    for (int j = 0; j < 3; j++) begin
      if (len > 6'd30) sc[j] = 30'(mag[j] >> (len - 6'd30));
      else sc[j] = 30'(mag[j] << (6'd30 - len));
    end
  end

  // square root step
  logic [63:0] sq_trial;
  assign sq_trial = {1'b0, sq_root} + {1'b0, sq_bit};

  // division step (restoring, one quotient bit per cycle)
  logic [31:0] dv_t [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dv_t[j] = {dv_r[j], dv_lo[j][30]};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      sq_v <= 1'b0;
      dv_v <= 1'b0;
    end else begin
      if (req_acc) s1_v <= 1'b1;
      else if (s2_ld) s1_v <= 1'b0;
      if (s2_ld) s2_v <= 1'b1;
      else if (s3_ld) s2_v <= 1'b0;
      if (s3_ld) s3_v <= 1'b1;
      else if (sq_ld) s3_v <= 1'b0;
      if (sq_ld) sq_v <= 1'b1;
      else if (dv_ld) sq_v <= 1'b0;
      if (dv_ld) dv_v <= 1'b1;
      else if (dv_rel) dv_v <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_h      <= '{req.data.center_x, req.data.center_y, req.data.center_z, req.data.radius};
      s1_dif[0] <= 33'(req.data.center_x) - 33'(req.data.start_x);
      s1_dif[1] <= 33'(req.data.center_y) - 33'(req.data.start_y);
      s1_dif[2] <= 33'(req.data.center_z) - 33'(req.data.start_z);
    end
    if (s2_ld) begin
      s2_h     <= s1_h;
      s2_sc    <= sc;
      s2_neg   <= {s1_dif[2][32], s1_dif[1][32], s1_dif[0][32]};
      s2_degen <= (mag_or == '0);
    end
    if (s3_ld) begin
      s3_h     <= s2_h;
      s3_sc    <= s2_sc;
      s3_neg   <= s2_neg;
      s3_degen <= s2_degen;
      for (int j = 0; j < 3; j++) begin
        s3_sq[j] <= 60'(s2_sc[j]) * 60'(s2_sc[j]);
      end
    end
    // square root: load or iterate
    if (sq_ld) begin
      sq_h     <= s3_h;
      sq_sc    <= s3_sc;
      sq_neg   <= s3_neg;
      sq_degen <= s3_degen;
      sq_rem   <= 62'(s3_sq[0]) + 62'(s3_sq[1]) + 62'(s3_sq[2]);
      sq_root  <= '0;
      sq_bit   <= {1'b1, 62'd0};
    end else if (sq_v && !sq_done) begin
      if ({2'b00, sq_rem} >= sq_trial) begin
        sq_rem  <= sq_rem - sq_trial[61:0];
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
    // divider: load or iterate
    if (dv_ld) begin
      dv_h     <= sq_h;
      dv_neg   <= sq_neg;
      dv_degen <= sq_degen;
      dv_n     <= sq_root[30:0];
      dv_cnt   <= 5'd31;
      for (int j = 0; j < 3; j++) begin
        dv_r[j]  <= {1'b0, sq_sc[j][29:1]};
        dv_lo[j] <= {sq_sc[j][0], sq_root[30:1]};
      end
    end else if (dv_v && dv_cnt != '0) begin
      dv_cnt <= dv_cnt - 5'd1;
      for (int j = 0; j < 3; j++) begin
        if (dv_t[j] >= {1'b0, dv_n}) begin
          dv_r[j]  <= 31'(dv_t[j] - {1'b0, dv_n});
          dv_lo[j] <= {dv_lo[j][29:0], 1'b1};
        end else begin
          dv_r[j]  <= dv_t[j][30:0];
          dv_lo[j] <= {dv_lo[j][29:0], 1'b0};
        end
      end
    end
  end

  // result: signed unit vector, zero when degenerate
  logic signed [31:0] u [3];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (dv_degen) u[j] = '0;
      else if (dv_neg[j]) u[j] = -$signed({1'b0, dv_lo[j]});
      else u[j] = $signed({1'b0, dv_lo[j]});
    end
  end

  assign ctx_valid      = dv_v && (dv_cnt == '0);
  assign ctx.cen_x      = dv_h.cx;
  assign ctx.cen_y      = dv_h.cy;
  assign ctx.cen_z      = dv_h.cz;
  assign ctx.radius     = dv_h.rad;
  assign ctx.ux         = u[0];
  assign ctx.uy         = u[1];
  assign ctx.uz         = u[2];
  assign ctx.degenerate = dv_degen;

endmodule

`default_nettype wire

FILE: sv/cwg_emit.sv
// Waypoint emitter: step sequencer and rotate/scale/offset pipeline.
`default_nettype none

module cwg_emit #(
  parameter int STEPS_PER_HALF_TURN = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          ctx_valid,
  output logic               ctx_ready,
  input  wire cwg_pkg::ctx_t ctx,
  cwg_pt_if.source           pt
);

  localparam int COUNT = 4 * STEPS_PER_HALF_TURN;
  localparam int D     = 2 * STEPS_PER_HALF_TURN;
  localparam int IW    = $clog2(COUNT + 1);
  localparam int TW    = (COUNT > 1) ? $clog2(COUNT) : 1;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic        [30:0] rad;
    logic        [4:0]  idx;
    logic               last;
    logic               degen;
  } meta_t;

  // cos/sin table of pi*i/N, i = 1 .. COUNT
  logic signed [31:0] cos_tab [COUNT];
  logic signed [31:0] sin_tab [COUNT];
  for (genvar g = 0; g < COUNT; g++) begin : g_tab
    localparam int K          = (g + 1) % D;
    localparam int QD         = (4 * K) / D;
    localparam int R          = 4 * K - QD * D;
    localparam logic [63:0] X = (cwg_pkg::PI_Q30 * 64'(R) + 64'(D)) / 64'(2 * D);
    localparam logic [63:0] CS = cwg_pkg::sincos_q30(X, 2'(QD));
    assign cos_tab[g] = CS[63:32];
    assign sin_tab[g] = CS[31:0];
  end

  logic          act;
  cwg_pkg::ctx_t cur;
  logic [IW-1:0] step;
  logic          en;
  logic          o_v;
  logic          at_end;

  assign en        = !o_v || pt.ready;
  assign at_end    = (step == IW'(COUNT));
  assign ctx_ready = !act || (en && at_end);

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (ctx_valid && ctx_ready) begin
      act <= 1'b1;
    end else if (en && act && at_end) begin
      act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctx_valid && ctx_ready) begin
      cur  <= ctx;
      step <= IW'(1);
    end else if (en && act) begin
      step <= step + IW'(1);
    end
  end

  // pipeline registers
  logic               v1, v2, v3, v4, v5, v6;
  meta_t              m1, m2, m3, m4, m5, m6;
  logic signed [31:0] c1, sn1, ux1, uy1, uz1;
  logic signed [63:0] pcx, psy, pcy, psx, pz;
  logic signed [63:0] sx3, sy3;
  logic signed [33:0] oz3, oz4, oz5, oz6;
  logic signed [33:0] rx4, ry4;
  logic signed [63:0] mx5, my5;
  logic signed [33:0] ox6, oy6;
  logic [TW-1:0]      tidx;

  assign tidx = TW'(step - IW'(1));

  // valid bits travel with the data; everything holds on a stall
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      o_v <= 1'b0;
    end else if (en) begin
      v1  <= act;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
      v5  <= v4;
      v6  <= v5;
      o_v <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // P1: table lookup
      c1  <= cos_tab[tidx];
      sn1 <= sin_tab[tidx];
      ux1 <= cur.ux;
      uy1 <= cur.uy;
      uz1 <= cur.uz;
      m1  <= '{cur.cen_x, cur.cen_y, cur.cen_z, cur.radius, 5'(step), at_end,
               cur.degenerate};
      // P2: rotation products and z offset product
      pcx <= 64'(c1) * 64'(ux1);
      psy <= 64'(sn1) * 64'(uy1);
      pcy <= 64'(c1) * 64'(uy1);
      psx <= 64'(sn1) * 64'(ux1);
      pz  <= 64'($signed({1'b0, m1.rad})) * 64'(uz1);
      m2  <= m1;
      // P3: rotated sums
      sx3 <= pcx + psy;
      sy3 <= pcy - psx;
      oz3 <= cwg_pkg::rnd30(pz);
      m3  <= m2;
      // P4: rotated unit vector in Q30
      rx4 <= cwg_pkg::rnd30(sx3);
      ry4 <= cwg_pkg::rnd30(sy3);
      oz4 <= oz3;
      m4  <= m3;
      // P5: scale by radius
      mx5 <= 64'($signed({1'b0, m4.rad})) * 64'(rx4);
      my5 <= 64'($signed({1'b0, m4.rad})) * 64'(ry4);
      oz5 <= oz4;
      m5  <= m4;
      // P6: offsets in Q16
      ox6 <= cwg_pkg::rnd30(mx5);
      oy6 <= cwg_pkg::rnd30(my5);
      oz6 <= oz5;
      m6  <= m5;
      // output register: center minus offset, saturated
      pt.data.point_x     <= cwg_pkg::sat32(36'(m6.cx) - 36'(ox6));
      pt.data.point_y     <= cwg_pkg::sat32(36'(m6.cy) - 36'(oy6));
      pt.data.point_z     <= cwg_pkg::sat32(36'(m6.cz) - 36'(oz6));
      pt.data.point_index <= m6.idx;
      pt.data.last        <= m6.last;
      pt.data.degenerate  <= m6.degen;
    end
  end

  assign pt.valid = o_v;

endmodule

`default_nettype wire

FILE: sv/circle_waypoint_generator_top.sv
// Top level of the circle waypoint generator.
//
//  channel | dir | payload                                       | transaction
//  req     | in  | center_x/y/z, start_x/y/z, radius             | one circle request
//  pt      | out | point_x/y/z, point_index, last, degenerate    | one waypoint
//
// Each request yields 4*STEPS_PER_HALF_TURN waypoints, one per cycle when pt is ready.
// Sustained request throughput is set by the bit-serial square root; the divider and
// the emitter overlap it by working on other requests.
// The first waypoint follows the square root, the divider and the emitter pipeline.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
// A stall on pt freezes the emitter pipeline; the front end keeps working until full.
`default_nettype none

module circle_waypoint_generator_top #(
  parameter int STEPS_PER_HALF_TURN = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  cwg_req_if.sink   req,
  cwg_pt_if.source  pt
);

  logic          ctx_valid;
  logic          ctx_ready;
  cwg_pkg::ctx_t ctx;

  // unit vector front end
  cwg_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctx_valid (ctx_valid),
    .ctx_ready (ctx_ready),
    .ctx       (ctx)
  );

  // waypoint emitter
  cwg_emit #(
    .STEPS_PER_HALF_TURN (STEPS_PER_HALF_TURN)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctx_valid (ctx_valid),
    .ctx_ready (ctx_ready),
    .ctx       (ctx),
    .pt        (pt)
  );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the circle waypoint generator: drives requests, predicts waypoints.
`default_nettype none

module testbench;

  localparam int NSTEP = 6;
  localparam int NPTS = 4 * NSTEP;
  localparam int N_RANDOM = 360;
  localparam longint CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  cwg_req_if req_ch();
  cwg_pt_if  pt_ch();

  circle_waypoint_generator_top #(.STEPS_PER_HALF_TURN(NSTEP)) DUT (
    .clk(clk), .rst(rst), .req(req_ch.sink), .pt(pt_ch.source)
  );

  // Integer sqrt, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned rem, root, b;
    rem = x; root = 0; b = 64'd1 << 62;
    while (b > rem && b != 0) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint round_q30(input longint v);
    if (v >= 0) return (v + 64'sd536870912) >>> 30;
    return -((-v + 64'sd536870912) >>> 30);
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Cosine and sine of pi*i/N in Q30
  function automatic void step_trig(input int i, output longint co, output longint so);
    longint unsigned d, k, q, r, x, x2, ts, tc, n;
    longint s, c;
    int sgn;
    d = 2 * NSTEP; k = i % d; q = (4 * k) / d; r = 4 * k - q * d;
    x = (64'd3373259426 * r + d) / (2 * d);
    x2 = (x * x + 64'd536870912) >> 30;
    s = x; c = 64'sd1073741824; ts = x; tc = 64'd1073741824; sgn = -1;
    for (n = 2; n <= 18; n += 2) begin
      ts = ((ts * x2) >> 30) / (n * (n + 1));
      tc = ((tc * x2) >> 30) / ((n - 1) * n);
      s = s + sgn * longint'(ts);
      c = c + sgn * longint'(tc);
      sgn = -sgn;
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    if (c < 0) c = 0;
    if (c > 64'sd1073741824) c = 64'sd1073741824;
    case (q)
      0: begin co = c;  so = s;  end
      1: begin co = -s; so = c;  end
      2: begin co = -c; so = -s; end
      default: begin co = s; so = -c; end
    endcase
  endfunction

  class waypoint_scoreboard;
    cwg_pkg::pt_t pending[$];
    int mismatches;
    int checked;

    // Predict every waypoint of one accepted request
    function void note_request(cwg_pkg::req_t rq);
      longint cen[3], dif[3], u[3], rad, c, s, rx, ry;
      longint unsigned mag[3], m, sum, nrm, qv;
      int len;
      cwg_pkg::pt_t p;
      cen[0] = rq.center_x; cen[1] = rq.center_y; cen[2] = rq.center_z;
      dif[0] = cen[0] - longint'(rq.start_x);
      dif[1] = cen[1] - longint'(rq.start_y);
      dif[2] = cen[2] - longint'(rq.start_z);
      m = 0; sum = 0; len = 0;
      for (int j = 0; j < 3; j++) begin
        mag[j] = dif[j] < 0 ? -dif[j] : dif[j];
        if (mag[j] > m) m = mag[j];
        u[j] = 0;
      end
      rad = rq.radius;
      if (m != 0) begin
        while (len < 64 && (m >> len) != 0) len++;
        for (int j = 0; j < 3; j++) begin
          mag[j] = len > 30 ? mag[j] >> (len - 30) : mag[j] << (30 - len);
          sum += mag[j] * mag[j];
        end
        nrm = int_sqrt(sum);
        for (int j = 0; j < 3; j++) begin
          qv = ((mag[j] << 30) + nrm / 2) / nrm;
          u[j] = dif[j] < 0 ? -longint'(qv) : longint'(qv);
        end
      end
      for (int i = 1; i <= NPTS; i++) begin
        step_trig(i, c, s);
        rx = round_q30(c * u[0] + s * u[1]);
        ry = round_q30(c * u[1] - s * u[0]);
        p.point_x = clamp32(cen[0] - round_q30(rad * rx));
        p.point_y = clamp32(cen[1] - round_q30(rad * ry));
        p.point_z = clamp32(cen[2] - round_q30(rad * u[2]));
        p.point_index = i[4:0];
        p.last = (i == NPTS);
        p.degenerate = (m == 0);
        pending.insert(pending.size(), p);
      end
    endfunction

    function void check_point(cwg_pkg::pt_t got);
      cwg_pkg::pt_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected waypoint %p", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  waypoint_scoreboard sb = new();
  longint cycles = 0;
  int sent = 0;
  bit calm = 0;         // no idling in the final stretch
  bit hold_sink = 0;    // long receiver stall request
  int accepted = 0;

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    pt_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL circle_waypoint_generator_top");
      $finish;
    end
  end

  // Monitors on both channels
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      sb.note_request(req_ch.data);
      accepted++;
    end
    if (!rst && pt_ch.valid && pt_ch.ready) sb.check_point(pt_ch.data);
  end

  // Receiver: random stall bursts, a long hold on request
  initial begin : sink_proc
    int burst;
    @(posedge clk iff !rst);
    forever begin
      if (hold_sink) begin
        pt_ch.ready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_sink = 0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 13);
        pt_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk);
      end else begin
        pt_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 4000) - 2000;
      3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic cwg_pkg::req_t random_req();
    cwg_pkg::req_t r;
    r.center_x = pick_coord(); r.center_y = pick_coord(); r.center_z = pick_coord();
    case ($urandom_range(0, 7))
      0: begin r.start_x = r.center_x; r.start_y = r.center_y; r.start_z = r.center_z; end
      1: begin
        r.start_x = r.center_x + $urandom_range(0, 6) - 3;
        r.start_y = r.center_y + $urandom_range(0, 6) - 3;
        r.start_z = r.center_z;
      end
      default: begin r.start_x = pick_coord(); r.start_y = pick_coord(); r.start_z = pick_coord(); end
    endcase
    case ($urandom_range(0, 4))
      0: r.radius = 31'h7fffffff;
      1: r.radius = 31'($urandom_range(0, 3));
      2: r.radius = 31'($urandom_range(0, 20) << 16);
      default: r.radius = 31'($urandom);
    endcase
    return r;
  endfunction

  // Offer one request and wait for acceptance
  task automatic send_req(input cwg_pkg::req_t r, input bit allow_gap);
    if (allow_gap && !calm && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  // Drop valid and let the monitor note the last transaction, then empty out
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic cwg_pkg::req_t make_req(input logic [31:0] cx, cy, cz, sx, sy, sz,
                                             input logic [30:0] rad);
    cwg_pkg::req_t r;
    r.center_x = cx; r.center_y = cy; r.center_z = cz;
    r.start_x = sx; r.start_y = sy; r.start_z = sz; r.radius = rad;
    return r;
  endfunction

  initial begin : main_proc
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: degenerate, axis directions, extremes and saturation
    send_req(make_req(0, 0, 0, 0, 0, 0, 31'h10000), 0);
    send_req(make_req(32'h7fffffff, 32'h80000000, 5, 32'h7fffffff, 32'h80000000, 5,
                      31'h7fffffff), 0);
    send_req(make_req(32'h10000, 0, 0, 0, 0, 0, 31'h20000), 0);
    send_req(make_req(0, 32'h10000, 0, 0, 0, 0, 31'h20000), 0);
    send_req(make_req(0, 0, 32'h10000, 0, 0, 0, 31'h7fffffff), 0);
    send_req(make_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                      32'h80000000, 32'h80000000, 32'h80000000, 31'h7fffffff), 0);
    send_req(make_req(32'h80000000, 32'h80000000, 32'h80000000,
                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff), 0);
    send_req(make_req(32'h7fffffff, 0, 0, 32'h7ffffffe, 0, 0, 31'h7fffffff), 0);
    send_req(make_req(32'hffffffff, 1, 32'hffffffff, 0, 0, 0, 31'd1), 0);
    send_req(make_req(32'h12345678, 32'hedcba987, 32'h00010000,
                      32'h00020000, 32'hfffe0000, 32'h00010000, 31'h00030000), 0);
    send_req(make_req(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 0, 31'd0),
             0);
    send_req(make_req(3, 4, 0, 0, 0, 0, 31'h55555555), 0);
    drain();

    // Long receiver hold while requests keep coming
    hold_sink = 1;
    for (int n = 0; n < 8; n++) send_req(random_req(), 0);
    drain();

    // Random part with bursts of idling; last stretch has none
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - 60) calm = 1;
      send_req(random_req(), 1);
      if (n == N_RANDOM / 2) drain();
    end
    drain();

    $display("covered %0d requests and %0d waypoints, incl. degenerate, saturating", sent,
             sb.checked);
    $display("and long-stall cases, %0d transactions taken, %0d mismatches", accepted,
             sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASS circle_waypoint_generator_top");
    else
      $display("FAIL circle_waypoint_generator_top");
    $finish;
  end
endmodule

`default_nettype wire
